FILE: rtl/pqt_pkg.sv
// Shared constants, codes and saturation helper for the quad tessellator.
`default_nettype none
package pqt_pkg;
	localparam int unsigned CoordW  = 32;
	localparam int unsigned IndexW  = 16;
	localparam int unsigned WidthW  = 16;
	localparam int unsigned CfgIdxW = 8;
	localparam int unsigned RootW   = 32;
	localparam int unsigned RadW    = 64;
	localparam int unsigned QuotW   = 24;

	localparam logic [CfgIdxW-1:0] RegPixOx  = 8'd0;
	localparam logic [CfgIdxW-1:0] RegPixOy  = 8'd1;
	localparam logic [CfgIdxW-1:0] RegPlotOx = 8'd2;
	localparam logic [CfgIdxW-1:0] RegPlotOy = 8'd3;
	localparam logic [CfgIdxW-1:0] RegScaleX = 8'd4;
	localparam logic [CfgIdxW-1:0] RegScaleY = 8'd5;
	localparam logic [CfgIdxW-1:0] RegWidth  = 8'd6;
	localparam logic [CfgIdxW-1:0] RegColor  = 8'd7;

	typedef logic signed [CoordW-1:0] coord_t;

	function automatic coord_t sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction
endpackage
`default_nettype wire

FILE: rtl/pqt_isqrt.sv
// Bit-serial floor square root of a 64-bit radicand, two radicand bits a cycle.
`default_nettype none
module pqt_isqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pqt_pkg::RadW-1:0]     radicand,
	output logic                              done,
	output logic [pqt_pkg::RootW-1:0]         root
);
	logic [pqt_pkg::RadW-1:0] v_q, res_q, bit_q;
	logic                     run_q;
	logic [pqt_pkg::RadW-1:0] trial;

	assign trial = res_q + bit_q;
	assign root  = res_q[pqt_pkg::RootW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q <= 1'b0;
				done  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(pqt_pkg::RadW-2){1'b0}}};
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/polyline_quad_tessellator_unit.sv
// Top level: plot-to-pixel mapping and thick segment quad expansion.
//
// channel  direction  handshake          payload
// in       sink       in_valid/in_stall  plot_x, plot_y, starts_line
// out      source     out_valid/out_stall vertex_x, vertex_y, vertex_index,
//                                        vertex_color, quad_done
// cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// A start point gives no output; a zero-length segment skips the square root and
// division. Any other segment runs the normalizing shift, the square root, two
// product and 24-step division passes, and 4 beats of output, with the products on
// one shared 32x32 multiplier.
// arst_n resets control, state and config only. out_stall holds the output beat
// and stops the emit steps; in_stall is high whenever an item is in work.
`default_nettype none
module polyline_quad_tessellator_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [pqt_pkg::CoordW-1:0] plot_x,
	input  wire logic signed [pqt_pkg::CoordW-1:0] plot_y,
	input  wire logic                            starts_line,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [pqt_pkg::CoordW-1:0]    vertex_x,
	output logic signed [pqt_pkg::CoordW-1:0]    vertex_y,
	output logic [pqt_pkg::IndexW-1:0]           vertex_index,
	output logic [pqt_pkg::CoordW-1:0]           vertex_color,
	output logic                                 quad_done,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pqt_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [pqt_pkg::CoordW-1:0]      cfg_data
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MX    = 4'd1;
	localparam logic [3:0] S_MY    = 4'd2;
	localparam logic [3:0] S_PY    = 4'd3;
	localparam logic [3:0] S_CHK   = 4'd4;
	localparam logic [3:0] S_NORM  = 4'd5;
	localparam logic [3:0] S_SQA   = 4'd6;
	localparam logic [3:0] S_SQB   = 4'd7;
	localparam logic [3:0] S_SQC   = 4'd8;
	localparam logic [3:0] S_SQRT  = 4'd9;
	localparam logic [3:0] S_MULH  = 4'd10;
	localparam logic [3:0] S_DINIT = 4'd11;
	localparam logic [3:0] S_DIV   = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;

	logic [3:0] state_q;

	pqt_pkg::coord_t pix_ox_q, pix_oy_q, plot_ox_q, plot_oy_q, scale_x_q, scale_y_q;
	logic [pqt_pkg::WidthW-1:0] width_q;
	logic [pqt_pkg::CoordW-1:0] color_q;

	pqt_pkg::coord_t in_x_q, in_y_q, px_q, py_q, prev_x_q, prev_y_q;
	logic in_start_q, have_prev_q;
	logic [pqt_pkg::IndexW-1:0] vcnt_q;

	logic [32:0] ax_q, ay_q, m;
	logic sx_q, sy_q, phase_q;
	logic signed [63:0] prod, prod_q;
	logic [63:0] acc_q;
	logic signed [31:0] ma, mb;
	logic [31:0] rem_q;
	logic [pqt_pkg::QuotW-1:0] dvd_q, quot_q, quot_n;
	logic [pqt_pkg::QuotW-1:0] ox_mag_q, oy_mag_q;
	logic [4:0] cnt_q;
	logic [1:0] k_q;
	logic [32:0] trial, len_ext;
	logic signed [32:0] dx, dy;
	logic sqrt_done;
	logic [pqt_pkg::RootW-1:0] root;
	logic [63:0] radicand;
	logic load;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);

	function automatic pqt_pkg::coord_t diff_sat(input pqt_pkg::coord_t a, input pqt_pkg::coord_t b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		return pqt_pkg::sat32({{31{d[32]}}, d});
	endfunction

	function automatic pqt_pkg::coord_t map_out(input logic signed [63:0] p, input pqt_pkg::coord_t o);
		logic signed [63:0] s;
		s = {{16{p[63]}}, p[63:16]} + {{32{o[31]}}, o};
		return pqt_pkg::sat32(s);
	endfunction

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_MX: begin
				ma = diff_sat(in_x_q, plot_ox_q);
				mb = scale_x_q;
			end
			S_MY: begin
				ma = diff_sat(in_y_q, plot_oy_q);
				mb = scale_y_q;
			end
			S_SQA: begin
				ma = ax_q[31:0];
				mb = ax_q[31:0];
			end
			S_SQB: begin
				ma = ay_q[31:0];
				mb = ay_q[31:0];
			end
			S_MULH: begin
				ma = phase_q ? ay_q[31:0] : ax_q[31:0];
				mb = {9'd0, width_q, 7'd0};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign prod = ma * mb;

	assign dx = {px_q[31], px_q} - {prev_x_q[31], prev_x_q};
	assign dy = {py_q[31], py_q} - {prev_y_q[31], prev_y_q};
	assign m  = (ax_q > ay_q) ? ax_q : ay_q;
	assign radicand = acc_q + prod_q;

	pqt_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SQC),
		.radicand (radicand),
		.done     (sqrt_done),
		.root     (root)
	);

	assign len_ext = {1'b0, root};
	assign trial   = {rem_q, dvd_q[pqt_pkg::QuotW-1]};
	assign quot_n  = {quot_q[pqt_pkg::QuotW-2:0], (trial >= len_ext)};

	logic signed [33:0] oxs, oys, bx, by, ex, ey;
	always_comb begin
		oxs = sx_q ? -$signed({10'd0, ox_mag_q}) : $signed({10'd0, ox_mag_q});
		oys = sy_q ? -$signed({10'd0, oy_mag_q}) : $signed({10'd0, oy_mag_q});
		if (k_q == 2'd0 || k_q == 2'd3) begin
			bx = {{2{prev_x_q[31]}}, prev_x_q};
			by = {{2{prev_y_q[31]}}, prev_y_q};
		end else begin
			bx = {{2{px_q[31]}}, px_q};
			by = {{2{py_q[31]}}, py_q};
		end
		if (k_q == 2'd0 || k_q == 2'd1) begin
			ex = bx + oys;
			ey = by - oxs;
		end else begin
			ex = bx - oys;
			ey = by + oxs;
		end
	end

	assign load = (state_q == S_EMIT) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ox_q  <= '0;
			pix_oy_q  <= '0;
			plot_ox_q <= '0;
			plot_oy_q <= '0;
			scale_x_q <= 32'sd65536;
			scale_y_q <= 32'sd65536;
			width_q   <= 16'd256;
			color_q   <= 32'hffffffff;
		end else if (cfg_valid) begin
			case (cfg_index)
				pqt_pkg::RegPixOx:  pix_ox_q  <= cfg_data;
				pqt_pkg::RegPixOy:  pix_oy_q  <= cfg_data;
				pqt_pkg::RegPlotOx: plot_ox_q <= cfg_data;
				pqt_pkg::RegPlotOy: plot_oy_q <= cfg_data;
				pqt_pkg::RegScaleX: scale_x_q <= cfg_data;
				pqt_pkg::RegScaleY: scale_y_q <= cfg_data;
				pqt_pkg::RegWidth:  width_q   <= cfg_data[pqt_pkg::WidthW-1:0];
				pqt_pkg::RegColor:  color_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			vcnt_q      <= '0;
			out_valid   <= 1'b0;
			phase_q     <= 1'b0;
			cnt_q       <= '0;
			k_q         <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_MX;
				end
				S_MX:  state_q <= S_MY;
				S_MY:  state_q <= S_PY;
				S_PY:  state_q <= S_CHK;
				S_CHK: begin
					if (in_start_q || !have_prev_q) begin
						prev_x_q    <= px_q;
						prev_y_q    <= py_q;
						have_prev_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (dx == 33'sd0 && dy == 33'sd0) begin
						k_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (m >= 33'h0_4000_0000 && m < 33'h0_8000_0000) state_q <= S_SQA;
				end
				S_SQA: state_q <= S_SQB;
				S_SQB: state_q <= S_SQC;
				S_SQC: state_q <= S_SQRT;
				S_SQRT: begin
					if (sqrt_done) begin
						phase_q <= 1'b0;
						state_q <= S_MULH;
					end
				end
				S_MULH: state_q <= S_DINIT;
				S_DINIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(pqt_pkg::QuotW - 1)) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= S_MULH;
						end else begin
							k_q     <= '0;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (load) begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3) begin
							prev_x_q <= px_q;
							prev_y_q <= py_q;
							vcnt_q   <= vcnt_q + 16'd4;
							state_q  <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod;
		if (state_q == S_IDLE && in_valid) begin
			in_x_q     <= plot_x;
			in_y_q     <= plot_y;
			in_start_q <= starts_line;
		end
		if (state_q == S_MY) px_q <= map_out(prod_q, pix_ox_q);
		if (state_q == S_PY) py_q <= map_out(prod_q, pix_oy_q);
		if (state_q == S_CHK) begin
			sx_q     <= dx[32];
			sy_q     <= dy[32];
			ax_q     <= dx[32] ? 33'(-dx) : 33'(dx);
			ay_q     <= dy[32] ? 33'(-dy) : 33'(dy);
			ox_mag_q <= '0;
			oy_mag_q <= '0;
		end
		if (state_q == S_NORM) begin
			if (m < 33'h0_0800_0000) begin
				ax_q <= ax_q << 4;
				ay_q <= ay_q << 4;
			end else if (m < 33'h0_4000_0000) begin
				ax_q <= ax_q << 1;
				ay_q <= ay_q << 1;
			end else if (m >= 33'h0_8000_0000) begin
				ax_q <= ax_q >> 1;
				ay_q <= ay_q >> 1;
			end
		end
		if (state_q == S_SQB) acc_q <= prod_q;
		if (state_q == S_DINIT) begin
			rem_q  <= prod_q[55:24];
			dvd_q  <= prod_q[23:0];
			quot_q <= '0;
		end
		if (state_q == S_DIV) begin
			if (trial >= len_ext) begin
				rem_q <= 32'(trial - len_ext);
			end else begin
				rem_q <= trial[31:0];
			end
			dvd_q  <= dvd_q << 1;
			quot_q <= quot_n;
			if (cnt_q == 5'(pqt_pkg::QuotW - 1)) begin
				if (!phase_q) ox_mag_q <= quot_n;
				else          oy_mag_q <= quot_n;
			end
		end
		if (load) begin
			vertex_x     <= pqt_pkg::sat32({{30{ex[33]}}, ex});
			vertex_y     <= pqt_pkg::sat32({{30{ey[33]}}, ey});
			vertex_index <= vcnt_q + {14'd0, k_q};
			vertex_color <= color_q;
			quad_done    <= (k_q == 2'd3);
		end
	end
endmodule
`default_nettype wire

FILE: sim/pqt_checker.sv
// Checker for the quad tessellator: mirrors the block, predicts corners and compares beats.
`timescale 1ns / 1ps
module pqt_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_stall,
	input  wire logic signed [pqt_pkg::CoordW-1:0]  plot_x,
	input  wire logic signed [pqt_pkg::CoordW-1:0]  plot_y,
	input  wire logic                               starts_line,
	input  wire logic                               out_valid,
	input  wire logic                               out_stall,
	input  wire logic signed [pqt_pkg::CoordW-1:0]  vertex_x,
	input  wire logic signed [pqt_pkg::CoordW-1:0]  vertex_y,
	input  wire logic [pqt_pkg::IndexW-1:0]         vertex_index,
	input  wire logic [pqt_pkg::CoordW-1:0]         vertex_color,
	input  wire logic                               quad_done,
	input  wire logic                               cfg_valid,
	input  wire logic                               cfg_ready,
	input  wire logic [pqt_pkg::CfgIdxW-1:0]        cfg_index,
	input  wire logic [pqt_pkg::CoordW-1:0]         cfg_data,
	output int                                      failures,
	output int                                      pending
);
	typedef struct packed {
		pqt_pkg::coord_t            x;
		pqt_pkg::coord_t            y;
		logic [pqt_pkg::IndexW-1:0] idx;
		logic [pqt_pkg::CoordW-1:0] color;
		logic                       done;
	} corner_t;

	corner_t corners_due[$];

	pqt_pkg::coord_t pix_ox, pix_oy, plot_ox, plot_oy, scl_x, scl_y;
	logic [pqt_pkg::WidthW-1:0] width_q88;
	logic [pqt_pkg::CoordW-1:0] color_q;
	logic signed [63:0] last_px, last_py;
	logic have_last;
	logic [pqt_pkg::IndexW-1:0] next_index;

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] to_pixel(input pqt_pkg::coord_t plot,
			input pqt_pkg::coord_t lo, input pqt_pkg::coord_t scale,
			input pqt_pkg::coord_t org);
		logic signed [63:0] p, l, s, o, d, m;
		p = plot;
		l = lo;
		s = scale;
		o = org;
		d = clamp32(p - l);
		m = (d * s) >>> 16;
		return clamp32(m + o);
	endfunction

	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic corner_t make_corner(input logic signed [63:0] x,
			input logic signed [63:0] y, input logic [pqt_pkg::IndexW-1:0] idx,
			input logic done);
		corner_t c;
		logic signed [63:0] cx, cy;
		cx = clamp32(x);
		cy = clamp32(y);
		c.x = cx[31:0];
		c.y = cy[31:0];
		c.idx = idx;
		c.color = color_q;
		c.done = done;
		return c;
	endfunction

	task automatic expand_point(input pqt_pkg::coord_t px_in, input pqt_pkg::coord_t py_in,
			input logic first);
		logic signed [63:0] px, py, dx, dy, ox, oy;
		logic [63:0] ax, ay, m, len, h;
		px = to_pixel(px_in, plot_ox, scl_x, pix_ox);
		py = to_pixel(py_in, plot_oy, scl_y, pix_oy);
		ox = 0;
		oy = 0;
		if (first || !have_last) begin
			last_px = px;
			last_py = py;
			have_last = 1'b1;
			return;
		end
		dx = px - last_px;
		dy = py - last_py;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		m = ax > ay ? ax : ay;
		if (m != 0) begin
			while (m < (64'h1 << 30)) begin
				m = m << 1; ax = ax << 1; ay = ay << 1;
			end
			while (m >= (64'h1 << 31)) begin
				m = m >> 1; ax = ax >> 1; ay = ay >> 1;
			end
			len = floor_root(ax * ax + ay * ay);
			h = {48'd0, width_q88} << 7;
			ox = (ax * h) / len;
			oy = (ay * h) / len;
			if (dx < 0) ox = -ox;
			if (dy < 0) oy = -oy;
		end
		corners_due = {corners_due,
			make_corner(last_px + oy, last_py - ox, next_index, 1'b0)};
		corners_due = {corners_due,
			make_corner(px + oy, py - ox, next_index + 16'd1, 1'b0)};
		corners_due = {corners_due,
			make_corner(px - oy, py + ox, next_index + 16'd2, 1'b0)};
		corners_due = {corners_due,
			make_corner(last_px - oy, last_py + ox, next_index + 16'd3, 1'b1)};
		next_index = next_index + 16'd4;
		last_px = px;
		last_py = py;
	endtask

	always @(posedge clk or negedge arst_n) begin
		corner_t exp_c;
		if (!arst_n) begin
			pix_ox = 0; pix_oy = 0; plot_ox = 0; plot_oy = 0;
			scl_x = 32'sd65536; scl_y = 32'sd65536;
			width_q88 = 16'd256; color_q = 32'hffffffff;
			last_px = 0; last_py = 0; have_last = 1'b0; next_index = 0;
			corners_due.delete();
			failures = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (corners_due.size() == 0) begin
					$error("vertex beat with nothing expected: index %0d", vertex_index);
					failures++;
				end else begin
					exp_c = corners_due.pop_front();
					if (vertex_x !== exp_c.x) begin
						$error("vertex_x expected %0d got %0d", exp_c.x, vertex_x);
						failures++;
					end
					if (vertex_y !== exp_c.y) begin
						$error("vertex_y expected %0d got %0d", exp_c.y, vertex_y);
						failures++;
					end
					if (vertex_index !== exp_c.idx) begin
						$error("vertex_index expected %0d got %0d", exp_c.idx, vertex_index);
						failures++;
					end
					if (vertex_color !== exp_c.color) begin
						$error("vertex_color expected %h got %h", exp_c.color, vertex_color);
						failures++;
					end
					if (quad_done !== exp_c.done) begin
						$error("quad_done expected %b got %b", exp_c.done, quad_done);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall) expand_point(plot_x, plot_y, starts_line);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pqt_pkg::RegPixOx:  pix_ox = cfg_data;
					pqt_pkg::RegPixOy:  pix_oy = cfg_data;
					pqt_pkg::RegPlotOx: plot_ox = cfg_data;
					pqt_pkg::RegPlotOy: plot_oy = cfg_data;
					pqt_pkg::RegScaleX: scl_x = cfg_data;
					pqt_pkg::RegScaleY: scl_y = cfg_data;
					pqt_pkg::RegWidth:  width_q88 = cfg_data[pqt_pkg::WidthW-1:0];
					pqt_pkg::RegColor:  color_q = cfg_data;
					default: ;
				endcase
			end
		end
		pending = corners_due.size();
	end
endmodule

FILE: sim/testbench.sv
// Testbench top: drives points and register writes into the tessellator and gives the verdict.
`timescale 1ns / 1ps
module testbench;
	localparam logic [pqt_pkg::CfgIdxW-1:0] RegUnused = 8'hff;
	localparam int CycleLimit = 200000;

	logic clk, arst_n;
	logic in_valid, in_stall, starts_line;
	pqt_pkg::coord_t plot_x, plot_y;
	logic out_valid, out_stall, quad_done;
	pqt_pkg::coord_t vertex_x, vertex_y;
	logic [pqt_pkg::IndexW-1:0] vertex_index;
	logic [pqt_pkg::CoordW-1:0] vertex_color;
	logic cfg_valid, cfg_ready;
	logic [pqt_pkg::CfgIdxW-1:0] cfg_index;
	logic [pqt_pkg::CoordW-1:0] cfg_data;
	int failures, pending, cycles;
	logic quiet;

	polyline_quad_tessellator_unit dut (.*);
	pqt_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		cycles = 0;
	end
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= !quiet && ($urandom_range(99) < 20);

	task automatic send_point(input pqt_pkg::coord_t x, input pqt_pkg::coord_t y,
			input logic first);
		while (!quiet && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		plot_x <= x;
		plot_y <= y;
		starts_line <= first;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(input logic [pqt_pkg::CfgIdxW-1:0] idx,
			input logic [pqt_pkg::CoordW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_regs(input pqt_pkg::coord_t pox, input pqt_pkg::coord_t poy,
			input pqt_pkg::coord_t lox, input pqt_pkg::coord_t loy,
			input pqt_pkg::coord_t sx, input pqt_pkg::coord_t sy,
			input logic [pqt_pkg::CoordW-1:0] w, input logic [pqt_pkg::CoordW-1:0] c);
		reg_write(pqt_pkg::RegPixOx, pox);
		reg_write(pqt_pkg::RegPixOy, poy);
		reg_write(pqt_pkg::RegPlotOx, lox);
		reg_write(pqt_pkg::RegPlotOy, loy);
		reg_write(pqt_pkg::RegScaleX, sx);
		reg_write(pqt_pkg::RegScaleY, sy);
		reg_write(pqt_pkg::RegWidth, w);
		reg_write(pqt_pkg::RegColor, c);
		reg_write(RegUnused, $urandom());
		cfg_valid <= 1'b0;
	endtask

	function automatic pqt_pkg::coord_t rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $signed($urandom_range(2000)) - 1000;
			default: return ($signed($urandom_range(400)) - 200) <<< 16;
		endcase
	endfunction

	task automatic random_lines(input int count);
		int n, seg;
		n = 0;
		while (n < count) begin
			if ($urandom_range(9) == 0) begin
				send_point(rand_coord(), rand_coord(), 1'($urandom_range(1)));
				n++;
			end else begin
				send_point(rand_coord(), rand_coord(), 1'b1);
				seg = $urandom_range(1, 8);
				repeat (seg) begin
					if ($urandom_range(15) == 0) send_point(plot_x, plot_y, 1'b0);
					else send_point(rand_coord(), rand_coord(), 1'b0);
				end
				n += seg + 1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		plot_x = 0;
		plot_y = 0;
		starts_line = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 0;
		cfg_data = 0;
		quiet = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		send_point(0, 0, 1'b0);
		send_point(5 <<< 16, 0, 1'b0);
		send_point(5 <<< 16, 0, 1'b0);
		send_point(5 <<< 16, 7 <<< 16, 1'b0);
		send_point(32'sh7fffffff, 32'sh7fffffff, 1'b0);
		send_point(32'sh80000000, 32'sh80000000, 1'b0);
		send_point(32'sh80000000, 32'sh7fffffff, 1'b0);
		send_point(1, 1, 1'b1);
		send_point(-(3 <<< 16), 4 <<< 16, 1'b0);
		send_point(0, 0, 1'b1);
		send_point(0, 0, 1'b0);
		send_point(1, 0, 1'b0);
		send_point(0, -1, 1'b0);
		drain();

		// extremes of every register
		load_regs(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh7fffffff, 32'sh80000000, 32'hffff, 32'h0);
		send_point(32'sh7fffffff, 32'sh80000000, 1'b1);
		send_point(0, 0, 1'b0);
		send_point(32'sh80000000, 32'sh7fffffff, 1'b0);
		send_point(100, -100, 1'b0);
		drain();
		load_regs(0, 0, 0, 0, 0, 0, 0, 32'h12345678);
		send_point(3 <<< 16, 4 <<< 16, 1'b0);
		send_point(9 <<< 16, 1 <<< 16, 1'b0);
		drain();

		// random settings and random polylines
		load_regs($urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom());
		random_lines(40);
		drain();
		load_regs(100 <<< 16, 200 <<< 16, -(50 <<< 16), 30 <<< 16,
			3 <<< 16, -(2 <<< 16), $urandom_range(1, 2048), $urandom());
		quiet = 1'b1;
		random_lines(40);
		quiet = 1'b0;
		random_lines(40);
		drain();
		load_regs(0, 0, 0, 0, 32'sh00010000, 32'sh00010000, 256, $urandom());
		random_lines(40);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

FILE: sim.f
rtl/pqt_pkg.sv
rtl/pqt_isqrt.sv
rtl/polyline_quad_tessellator_unit.sv
sim/pqt_checker.sv
sim/testbench.sv
